### hdl/gcs_pkg.sv
package gcs_pkg;

    localparam int LEN_W           = 16;
    localparam int SUM_W           = 56;
    localparam int ERR_W           = 41;
    localparam int LVL_W           = 7;
    localparam int LOG_W           = 30;
    localparam int MQ_W            = 15;
    localparam int GCF_W           = 17;
    localparam int MAX_READ_LENGTH = 65535;
    localparam int QUALITY_LEVELS  = 100;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_PTR_W      = 2;
    localparam int FIFO_CNT_W      = 3;

    localparam logic [6:0]  QUAL_OFFSET_RST = 7'd33;
    localparam logic [63:0] DEC_ONE         = 64'd10000000000000000;
    localparam logic [31:0] TEN_LOG10_2_Q30 = 32'd3232284966;

    localparam logic [63:0] DECADE_MANT [10] = '{
        64'd10000000000000000, 64'd7943282347242815, 64'd6309573444801932,
        64'd5011872336272722,  64'd3981071705534972, 64'd3162277660168379,
        64'd2511886431509580,  64'd1995262314968880, 64'd1584893192461113,
        64'd1258925411794167
    };

    typedef logic [ERR_W-1:0] rom_t [QUALITY_LEVELS];

    // restoring long division of two constants
    function automatic logic [127:0] const_div(logic [127:0] num, logic [127:0] den);
        logic [127:0] quo;
        logic [127:0] rem;
        int           i;
        quo = '0;
        rem = '0;
        for (i = 127; i >= 0; i--)
        begin
            rem = {rem[126:0], num[i]};
            quo = {quo[126:0], 1'b0};
            if (rem >= den)
            begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // entry q = round(2^40 * 10^(-(q mod 10)/10)) rounded again by 10^(q div 10)
    function automatic rom_t build_rom();
        rom_t         r;
        logic [127:0] quo;
        logic [127:0] p10;
        int           d;
        int           m;
        int           q;
        int           k;
        for (d = 0; d * 10 < QUALITY_LEVELS; d++)
        begin
            for (m = 0; m < 10; m++)
            begin
                q = d * 10 + m;
                if (q < QUALITY_LEVELS)
                begin
                    quo = const_div(128'(DECADE_MANT[m]) << 41, 128'(DEC_ONE));
                    quo = (quo + 128'd1) >> 1;
                    p10 = 128'd1;
                    for (k = 0; k < d && k < 19; k++)
                        p10 = p10 * 128'd10;
                    r[q] = ERR_W'(const_div(quo + (p10 >> 1), p10));
                end
            end
        end
        return r;
    endfunction

    localparam rom_t ERR_ROM = build_rom();

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] gc;
        logic [SUM_W-1:0] sum;
        logic             ovf;
    } rec_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_NORM,
        BK_SQR,
        BK_MUL,
        BK_RND
    } back_state_t;

endpackage

### hdl/gcs_ifs.sv
interface gcs_base_if;
    logic       valid;
    logic       ready;
    logic [7:0] base_char;
    logic [7:0] quality_char;
    logic       last_base;
    modport source (output valid, base_char, quality_char, last_base, input ready);
    modport sink   (input valid, base_char, quality_char, last_base, output ready);
endinterface

interface gcs_stats_if;
    logic        valid;
    logic        ready;
    logic [15:0] read_length;
    logic [14:0] mean_quality;
    logic [16:0] gc_fraction;
    logic        length_saturated;
    modport source (output valid, read_length, mean_quality, gc_fraction,
                    length_saturated, input ready);
    modport sink   (input valid, read_length, mean_quality, gc_fraction,
                    length_saturated, output ready);
endinterface

interface gcs_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hdl/gcs_front.sv
module gcs_front
    import gcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    gcs_base_if.sink              bases,
    gcs_cfg_if.sink               cfg,
    input  logic [FIFO_CNT_W-1:0] fifo_count,
    output logic                  push,
    output rec_t                  push_rec
);

    logic [6:0]       offset_reg;
    logic             s1_valid_reg;
    logic [ERR_W-1:0] s1_err_reg;
    logic             s1_gc_reg;
    logic             s1_last_reg;
    logic [LEN_W-1:0] count_reg, count_next, count_acc;
    logic [LEN_W-1:0] gc_reg, gc_next, gc_acc;
    logic [SUM_W-1:0] sum_reg, sum_next, sum_acc;
    logic             ovf_reg, ovf_next, ovf_acc;
    logic [8:0]       diff;
    logic [LVL_W-1:0] lvl;
    logic             is_gc;
    logic             accept;

    assign cfg.ready   = 1'b1;
    // at most one last base can sit in the first stage, so keep one slot spare
    assign bases.ready = fifo_count < FIFO_CNT_W'(FIFO_DEPTH - 1);
    assign accept      = bases.valid && bases.ready;

    always_comb
    begin
        diff = {1'b0, bases.quality_char} - {2'b00, offset_reg};
        if (diff[8])
            lvl = '0;
        else if (diff > 9'(QUALITY_LEVELS - 1))
            lvl = LVL_W'(QUALITY_LEVELS - 1);
        else
            lvl = diff[LVL_W-1:0];
        is_gc = (bases.base_char == "C") || (bases.base_char == "c") ||
                (bases.base_char == "G") || (bases.base_char == "g");
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg   <= QUAL_OFFSET_RST;
            s1_valid_reg <= 1'b0;
            count_reg    <= '0;
            gc_reg       <= '0;
            sum_reg      <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                offset_reg <= cfg.data;
            s1_valid_reg <= accept;
            count_reg    <= count_next;
            gc_reg       <= gc_next;
            sum_reg      <= sum_next;
            ovf_reg      <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_err_reg  <= ERR_ROM[lvl];
            s1_gc_reg   <= is_gc;
            s1_last_reg <= bases.last_base;
        end
    end

    always_comb
    begin
        count_acc = count_reg;
        gc_acc    = gc_reg;
        sum_acc   = sum_reg;
        ovf_acc   = ovf_reg;
        if (s1_valid_reg)
        begin
            if (count_reg == LEN_W'(MAX_READ_LENGTH))
                ovf_acc = 1'b1;
            else
            begin
                count_acc = count_reg + 1'b1;
                sum_acc   = sum_reg + SUM_W'(s1_err_reg);
                gc_acc    = gc_reg + LEN_W'(s1_gc_reg);
            end
        end
        push          = s1_valid_reg && s1_last_reg;
        push_rec.len  = count_acc;
        push_rec.gc   = gc_acc;
        push_rec.sum  = sum_acc;
        push_rec.ovf  = ovf_acc;
        // clear for the next read once the totals leave
        count_next = push ? '0 : count_acc;
        gc_next    = push ? '0 : gc_acc;
        sum_next   = push ? '0 : sum_acc;
        ovf_next   = push ? 1'b0 : ovf_acc;
    end

endmodule

### hdl/gcs_fifo.sv
module gcs_fifo
    import gcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  rec_t                  push_rec,
    input  logic                  pop,
    output rec_t                  pop_rec,
    output logic                  not_empty,
    output logic [FIFO_CNT_W-1:0] count
);

    rec_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_reg, rd_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;

    assign pop_rec   = mem_reg[rd_reg];
    assign not_empty = cnt_reg != '0;
    assign count     = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_rec;
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg < FIFO_CNT_W'(FIFO_DEPTH)) || pop)
        else $error("queue overrun");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != '0)
        else $error("queue underrun");

endmodule

### hdl/gcs_back.sv
module gcs_back
    import gcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fifo_valid,
    input  rec_t        fifo_rec,
    output logic        pop,
    gcs_stats_if.source stats
);

    back_state_t      state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic             ovf_reg, ovf_next;
    logic [32:0]      num_reg, num_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [GCF_W-1:0] q_reg, q_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [SUM_W-1:0] w_reg, w_next;
    logic [5:0]       n_reg, n_next;
    logic [31:0]      y_reg, y_next;
    logic [LOG_W-1:0] res_reg, res_next;
    logic [4:0]       step_reg, step_next;
    logic             sel_reg, sel_next;
    logic [LOG_W-1:0] llen_reg, llen_next;
    logic [LOG_W-1:0] d_reg, d_next;
    logic [61:0]      prod_reg, prod_next;
    logic             out_valid_reg, out_valid_next;
    logic [LEN_W-1:0] out_len_reg, out_len_next;
    logic [MQ_W-1:0]  out_mq_reg, out_mq_next;
    logic [GCF_W-1:0] out_gcf_reg, out_gcf_next;
    logic             out_ovf_reg, out_ovf_next;

    logic [16:0]      trial;
    logic             ge;
    logic [16:0]      trial_sub;
    logic [63:0]      sq;
    logic [LOG_W-1:0] res_fin;
    logic [LOG_W:0]   d_a;
    logic [LOG_W:0]   d_b;
    logic [62:0]      rnd;
    logic [16:0]      mq_wide;
    logic             load;

    assign stats.valid            = out_valid_reg;
    assign stats.read_length      = out_len_reg;
    assign stats.mean_quality     = out_mq_reg;
    assign stats.gc_fraction      = out_gcf_reg;
    assign stats.length_saturated = out_ovf_reg;

    assign load = (state_reg == BK_RND) && (!out_valid_reg || stats.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (fifo_valid) state_next = BK_DIV;
            BK_DIV:  if (cnt_reg == '0) state_next = BK_NORM;
            BK_NORM: if (w_reg[SUM_W-1]) state_next = BK_SQR;
            BK_SQR:
            begin
                if (step_reg == '0)
                    state_next = (!sel_reg && sum_reg != '0) ? BK_NORM : BK_MUL;
            end
            BK_MUL:  state_next = BK_RND;
            BK_RND:  if (load) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        len_next       = len_reg;
        sum_next       = sum_reg;
        ovf_next       = ovf_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        w_next         = w_reg;
        n_next         = n_reg;
        y_next         = y_reg;
        res_next       = res_reg;
        step_next      = step_reg;
        sel_next       = sel_reg;
        llen_next      = llen_reg;
        d_next         = d_reg;
        prod_next      = prod_reg;
        out_len_next   = out_len_reg;
        out_mq_next    = out_mq_reg;
        out_gcf_next   = out_gcf_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && !stats.ready;
        pop            = 1'b0;

        trial     = {rem_reg, num_reg[32]};
        ge        = trial >= {1'b0, len_reg};
        trial_sub = trial - {1'b0, len_reg};
        sq        = 64'(y_reg) * 64'(y_reg);
        res_fin   = sq[63] ? (res_reg | (LOG_W'(1) << step_reg)) : res_reg;
        d_a       = {1'b0, llen_reg} + (LOG_W + 1)'(40 << 24);
        d_b       = {1'b0, res_fin};
        rnd       = {1'b0, prod_reg} + (63'(1) << 45);
        mq_wide   = rnd[62:46];

        case (state_reg)
            BK_IDLE:
            begin
                if (fifo_valid)
                begin
                    pop      = 1'b1;
                    len_next = fifo_rec.len;
                    sum_next = fifo_rec.sum;
                    ovf_next = fifo_rec.ovf;
                    // numerator carries the half-divisor for rounding
                    num_next = {1'b0, fifo_rec.gc, 16'h0000} + 33'(fifo_rec.len >> 1);
                    rem_next = '0;
                    cnt_next = 6'd32;
                end
            end
            BK_DIV:
            begin
                rem_next = ge ? trial_sub[LEN_W-1:0] : trial[LEN_W-1:0];
                num_next = {num_reg[31:0], 1'b0};
                q_next   = {q_reg[GCF_W-2:0], ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    w_next   = SUM_W'(len_reg);
                    n_next   = 6'(SUM_W - 1);
                    sel_next = 1'b0;
                end
            end
            BK_NORM:
            begin
                if (w_reg[SUM_W-1])
                begin
                    y_next    = w_reg[SUM_W-1:SUM_W-32];
                    res_next  = {n_reg, 24'h000000};
                    step_next = 5'd23;
                end
                else
                begin
                    w_next = {w_reg[SUM_W-2:0], 1'b0};
                    n_next = n_reg - 1'b1;
                end
            end
            BK_SQR:
            begin
                res_next  = res_fin;
                y_next    = sq[63] ? sq[63:32] : sq[62:31];
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    if (!sel_reg)
                    begin
                        llen_next = res_fin;
                        d_next    = '0;
                        w_next    = sum_reg;
                        n_next    = 6'(SUM_W - 1);
                        sel_next  = 1'b1;
                    end
                    else
                    begin
                        // a negative difference clamps to zero
                        d_next = (d_a >= d_b) ? LOG_W'(d_a - d_b) : '0;
                    end
                end
            end
            BK_MUL:
            begin
                prod_next = 62'(d_reg) * 62'(TEN_LOG10_2_Q30);
            end
            BK_RND:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = len_reg;
                    out_mq_next    = (mq_wide > 17'd32767) ? 15'h7fff : mq_wide[MQ_W-1:0];
                    out_gcf_next   = (len_reg == '0) ? '0 : q_reg;
                    out_ovf_next   = ovf_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !stats.ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg     <= len_next;
        sum_reg     <= sum_next;
        ovf_reg     <= ovf_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        cnt_reg     <= cnt_next;
        w_reg       <= w_next;
        n_reg       <= n_next;
        y_reg       <= y_next;
        res_reg     <= res_next;
        step_reg    <= step_next;
        sel_reg     <= sel_next;
        llen_reg    <= llen_next;
        d_reg       <= d_next;
        prod_reg    <= prod_next;
        out_len_reg <= out_len_next;
        out_mq_reg  <= out_mq_next;
        out_gcf_reg <= out_gcf_next;
        out_ovf_reg <= out_ovf_next;
    end

    a_norm_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_NORM) |-> w_reg != '0)
        else $error("normalizing a zero operand");

    a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV) && (cnt_reg != 6'd32) |-> rem_reg < len_reg)
        else $error("divider remainder out of range");

    a_gc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_gcf_reg <= 17'd65536)
        else $error("gc fraction above one");

endmodule

### hdl/read_quality_gc_stats_unit.sv
// Read quality and GC statistics unit.
// bases: one base request per cycle while ready (base letter, quality byte,
//   last mark). Each base is looked up at acceptance and added to the read
//   totals on the next cycle; the last base reaches the result queue then.
// stats: one result per read (length, mean Phred quality in Q7.8,
//   GC fraction in Q1.16, saturation flag) after the last base.
// cfg: writes the quality offset; always ready, takes effect on the next base.
// Throughput: bases stream at one per cycle while input ready is high. The
//   back stage takes one read at a time through the bit-serial divider,
//   the one-bit normalizer and the squaring log loop; up to four finished
//   reads queue in front of it.
// Input ready drops while the result queue has fewer than two free slots.
// When stats is stalled, the finished result holds in the output register;
//   the back stage computes the next read and then waits for that slot.
// Reset clears the read counters, the queue and the output valid flag, and
//   sets the quality offset to 33.
module read_quality_gc_stats_unit
    import gcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    gcs_base_if.sink    bases,
    gcs_cfg_if.sink     cfg,
    gcs_stats_if.source stats
);

    logic                  push;
    rec_t                  push_rec;
    logic                  pop;
    rec_t                  pop_rec;
    logic                  not_empty;
    logic [FIFO_CNT_W-1:0] fifo_count;

    gcs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bases      (bases),
        .cfg        (cfg),
        .fifo_count (fifo_count),
        .push       (push),
        .push_rec   (push_rec)
    );

    gcs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_rec  (push_rec),
        .pop       (pop),
        .pop_rec   (pop_rec),
        .not_empty (not_empty),
        .count     (fifo_count)
    );

    gcs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_valid (not_empty),
        .fifo_rec   (pop_rec),
        .pop        (pop),
        .stats      (stats)
    );

endmodule
